[rtl/core/qmbae_pkg.sv]
// qmbae_pkg: shared types and constants for the qm binary arithmetic encoder
// used by the controller, datapath, top level and port checker; no dependencies

package qmbae_pkg;

    // default probability table depth
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // interval and code widths
    localparam int INTERVAL_W = 17;
    localparam int CODE_W     = 16;
    localparam int SHIFT_CNT_W = 5;

    localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET = 17'h10000;
    localparam logic [CODE_W-1:0]      CODE_RESET     = 16'h0000;
    localparam logic [SHIFT_CNT_W-1:0] MAX_SHIFTS     = 5'd16;

    // action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    // step-down code that swaps the mps instead of moving the pointer
    localparam logic [1:0] STEP_DOWN_SWAP = 2'd0;

    // input beat
    typedef struct packed {
        logic        action;
        logic        bit_value;
        logic [5:0]  entry_index;
        logic [15:0] entry_prob;
        logic        entry_step_up;
        logic [1:0]  entry_step_down;
    } item_t;

    // output beat
    typedef struct packed {
        logic out_bit;
        logic last_of_run;
    } result_t;

    // one probability table entry
    typedef struct packed {
        logic [15:0] prob;
        logic        step_up;
        logic [1:0]  step_down;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic eval;
        logic emit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic has_bit;
        logic is_last;
        logic out_free;
    } dp_status_t;

endpackage

[rtl/core/qm_binary_arithmetic_encoder_core.sv]
// qm_binary_arithmetic_encoder_core: top level of the single-context qm encoder
// depends on qmbae_pkg, qmbae_ctrl and qmbae_datapath
//
// usage:
//   item channel (item_valid / item_stall / item): a load beat (action 0) writes
//   one probability table entry; entries at or beyond TABLE_DEPTH are dropped.
//   an encode beat (action 1) codes bit_value against the current table entry.
//   result channel (result_valid / result_stall / result): one beat per emitted
//   code bit, last_of_run set on the final beat of an encode item.
// sequence:
//   a load beat writes the table and the block stays ready.
//   an encode beat passes an evaluate state, then the renormalizer emits one
//   bit per cycle into the output register while that register is free; an
//   item gives up to 17 result beats (possibly none) and holds the input.
//   first result beat goes through the evaluate and emit states, then the
//   output register; the shifter of interval and code moves one bit per emit.
// reset: interval goes to 0x10000, code, pointer and mps to zero; table
//   contents are undefined until loaded.
// stall: a stalled result beat holds in the output register and the shifter
//   waits; the final beat may sit there while the next item is taken.

module qm_binary_arithmetic_encoder_core #(
    parameter int TABLE_DEPTH = qmbae_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  qmbae_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output qmbae_pkg::result_t result
);

    qmbae_pkg::dp_cmd_t    cmd;
    qmbae_pkg::dp_status_t status;

    // sequencing
    qmbae_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_action (item.action),
        .cmd         (cmd),
        .status      (status)
    );

    // table, arithmetic and output register
    qmbae_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[rtl/core/qmbae_ctrl.sv]
// qmbae_ctrl: sequencing state machine of the qm binary arithmetic encoder
// depends on qmbae_pkg; drives qmbae_datapath through command and status structs

module qmbae_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  item_action,
    output qmbae_pkg::dp_cmd_t    cmd,
    input  qmbae_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   stall_reg;
    logic   accept;

    assign item_stall = stall_reg;
    assign accept     = item_valid && !stall_reg;

    // commands to the datapath
    always_comb
    begin
        cmd       = '0;
        cmd.load  = accept && (item_action == qmbae_pkg::ACT_LOAD);
        cmd.start = accept && (item_action == qmbae_pkg::ACT_ENCODE);
        cmd.eval  = (state_reg == ST_EVAL);
        cmd.emit  = (state_reg == ST_EMIT) && status.has_bit && status.out_free;
    end

    // state and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.start)
                    begin
                        state_reg <= ST_EVAL;
                        stall_reg <= 1'b1;
                    end
                end
                ST_EVAL:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!status.has_bit || (cmd.emit && status.is_last))
                    begin
                        state_reg <= ST_IDLE;
                        stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    stall_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

[rtl/core/qmbae_datapath.sv]
// qmbae_datapath: probability table, interval/code arithmetic, renormalization
// and output register; depends on qmbae_pkg, commanded by qmbae_ctrl

module qmbae_datapath #(
    parameter int TABLE_DEPTH = qmbae_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qmbae_pkg::item_t      item,
    output qmbae_pkg::result_t    result,
    output logic                  result_valid,
    input  logic                  result_stall,
    input  qmbae_pkg::dp_cmd_t    cmd,
    output qmbae_pkg::dp_status_t status
);

    localparam int PW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IXW = ((PW > 6) ? PW : 6) + 1;
    localparam int IW  = qmbae_pkg::INTERVAL_W;
    localparam int CW  = qmbae_pkg::CODE_W;
    localparam int SW  = qmbae_pkg::SHIFT_CNT_W;
    localparam logic [PW:0]     PTR_MAX   = (PW+1)'(TABLE_DEPTH - 1);
    localparam logic [IXW-1:0]  DEPTH_IX  = IXW'(TABLE_DEPTH);

    // probability table memory, read port runs every cycle at the pointer
    qmbae_pkg::entry_t table_mem [TABLE_DEPTH];
    qmbae_pkg::entry_t entry_reg;

    logic [IXW-1:0] idx_ext;
    logic           idx_ok;
    logic [PW-1:0]  wr_addr;

    // coder state
    logic [IW-1:0] interval_reg, interval_next;
    logic [CW-1:0] code_reg, code_next;
    logic [PW-1:0] ptr_reg, ptr_next;
    logic          mps_reg, mps_next;
    logic          carry_reg, carry_next;
    logic [SW-1:0] shift_cnt_reg, shift_cnt_next;
    logic          bit_reg;

    // output register
    qmbae_pkg::result_t result_reg;
    logic               result_valid_reg;

    // evaluation terms
    logic [IW-1:0] q_ext;
    logic [IW-1:0] diff;
    logic          diff_half;
    logic          diff_lt_q;
    logic [IW:0]   sum;
    logic          mps_hit;
    logic          take_add;
    logic [PW:0]   ptr_up;
    logic [PW-1:0] ptr_up_sat;
    logic [PW+1:0] ptr_w;
    logic [PW+1:0] dn_w;
    logic [PW+1:0] ptr_dn_w;
    logic [PW-1:0] ptr_dn_sat;

    // emit terms
    logic          shift_pending;
    logic          emit_bit;
    logic          emit_last;

    // load address decode
    assign idx_ext = IXW'(item.entry_index);
    assign idx_ok  = idx_ext < DEPTH_IX;
    assign wr_addr = idx_ext[PW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load && idx_ok)
        begin
            table_mem[wr_addr] <= '{prob:      item.entry_prob,
                                    step_up:   item.entry_step_up,
                                    step_down: item.entry_step_down};
        end
        entry_reg <= table_mem[ptr_reg];
    end

    // interval subtract, exchange decision and code add
    always_comb
    begin
        q_ext     = {1'b0, entry_reg.prob};
        diff      = interval_reg - q_ext;
        diff_half = diff[IW-1] | diff[IW-2];
        diff_lt_q = diff < q_ext;
        sum       = (IW+1)'(code_reg) + (IW+1)'(diff);
        mps_hit   = (bit_reg == mps_reg);
        take_add  = mps_hit ? (!diff_half && diff_lt_q) : !diff_lt_q;
    end

    // pointer steps, saturating at both table ends
    always_comb
    begin
        ptr_up     = (PW+1)'(ptr_reg) + (PW+1)'(entry_reg.step_up);
        ptr_up_sat = (ptr_up > PTR_MAX) ? PTR_MAX[PW-1:0] : ptr_up[PW-1:0];
        ptr_w      = (PW+2)'(ptr_reg);
        dn_w       = (PW+2)'(entry_reg.step_down);
        ptr_dn_w   = ptr_w - dn_w;
        ptr_dn_sat = (ptr_w >= dn_w) ? ptr_dn_w[PW-1:0] : '0;
    end

    // renormalization bit selection
    always_comb
    begin
        shift_pending = !interval_reg[IW-1] && !interval_reg[IW-2]
                        && (shift_cnt_reg != qmbae_pkg::MAX_SHIFTS);
        if (carry_reg)
        begin
            emit_bit  = 1'b1;
            emit_last = interval_reg[IW-1] | interval_reg[IW-2];
        end
        else
        begin
            emit_bit  = code_reg[CW-1];
            emit_last = interval_reg[IW-3]
                        || (shift_cnt_reg == qmbae_pkg::MAX_SHIFTS - SW'(1));
        end
    end

    assign status.has_bit  = carry_reg || shift_pending;
    assign status.is_last  = emit_last;
    assign status.out_free = !result_valid_reg || !result_stall;

    // next state of the coder registers
    always_comb
    begin
        interval_next  = interval_reg;
        code_next      = code_reg;
        ptr_next       = ptr_reg;
        mps_next       = mps_reg;
        carry_next     = carry_reg;
        shift_cnt_next = shift_cnt_reg;
        if (cmd.eval)
        begin
            interval_next  = take_add ? q_ext : diff;
            code_next      = take_add ? sum[CW-1:0] : code_reg;
            carry_next     = take_add && (sum[IW:CW] != '0);
            shift_cnt_next = '0;
            if (mps_hit)
            begin
                if (!diff_half)
                begin
                    ptr_next = ptr_up_sat;
                end
            end
            else
            begin
                if (entry_reg.step_down == qmbae_pkg::STEP_DOWN_SWAP)
                begin
                    mps_next = !mps_reg;
                end
                ptr_next = ptr_dn_sat;
            end
        end
        else if (cmd.emit)
        begin
            if (carry_reg)
            begin
                carry_next = 1'b0;
            end
            else
            begin
                interval_next  = {interval_reg[IW-2:0], 1'b0};
                code_next      = {code_reg[CW-2:0], 1'b0};
                shift_cnt_next = shift_cnt_reg + SW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg     <= qmbae_pkg::INTERVAL_RESET;
            code_reg         <= qmbae_pkg::CODE_RESET;
            ptr_reg          <= '0;
            mps_reg          <= 1'b0;
            carry_reg        <= 1'b0;
            shift_cnt_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            interval_reg  <= interval_next;
            code_reg      <= code_next;
            ptr_reg       <= ptr_next;
            mps_reg       <= mps_next;
            carry_reg     <= carry_next;
            shift_cnt_reg <= shift_cnt_next;
            if (cmd.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            bit_reg <= item.bit_value;
        end
        if (cmd.emit)
        begin
            result_reg <= '{out_bit: emit_bit, last_of_run: emit_last};
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

[rtl/core/qmbae_checker.sv]
// qmbae_checker: port-level assertions for the qm binary arithmetic encoder
// depends on qmbae_pkg; bound to qm_binary_arithmetic_encoder_core below

module qmbae_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input qmbae_pkg::item_t   item,
    input logic               result_valid,
    input logic               result_stall,
    input qmbae_pkg::result_t result
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result beat changed");

    // an encode beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.action == qmbae_pkg::ACT_ENCODE)
        |=> item_stall)
        else $error("encode beat did not stall input");

    // a load beat leaves the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.action == qmbae_pkg::ACT_LOAD)
        |=> !item_stall)
        else $error("load beat stalled input");

    // input stays stalled until the run's last beat is out
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_of_run |-> item_stall)
        else $error("input ready in the middle of a run");

endmodule

bind qm_binary_arithmetic_encoder_core qmbae_checker u_qmbae_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[sim/qmbae_code_bit_checker.sv]
// qmbae_code_bit_checker: watches both channels of the qm encoder, predicts the
// emitted code bits from its own copy of the coder state and compares each beat
// depends on qmbae_pkg

module qmbae_code_bit_checker #(
    parameter int TABLE_DEPTH = qmbae_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  qmbae_pkg::item_t   item,
    input  logic               result_valid,
    input  logic               result_stall,
    input  qmbae_pkg::result_t result,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;
    localparam int INTERVAL_W  = qmbae_pkg::INTERVAL_W;
    localparam int CODE_W      = qmbae_pkg::CODE_W;
    localparam logic [INTERVAL_W-1:0] HALF_MARK = 17'h08000;

    // predicted coder state
    logic [CODE_W-1:0]     est_table [TABLE_DEPTH];
    logic                  up_table [TABLE_DEPTH];
    logic [1:0]            down_table [TABLE_DEPTH];
    int unsigned           state_ptr;
    logic [INTERVAL_W-1:0] span;
    logic [CODE_W-1:0]     low_code;
    logic                  mps;

    // code bits still to arrive, oldest first
    qmbae_pkg::result_t code_bits_q [$];

    // code add, a carry out of 16 bits is flagged and dropped
    task automatic add_to_code(input logic [INTERVAL_W-1:0] amount,
                               inout logic carry);
        logic [INTERVAL_W:0] sum;
        sum = {2'b00, low_code} + {1'b0, amount};
        if (sum[INTERVAL_W:CODE_W] != '0)
            carry = 1'b1;
        low_code = sum[CODE_W-1:0];
    endtask

    // one encode step: interval update, pointer step, renormalization
    task automatic encode_symbol(input logic symbol);
        int unsigned           idx;
        int unsigned           shifts;
        int unsigned           emitted;
        int unsigned           next_ptr;
        logic [CODE_W-1:0]     est;
        logic [INTERVAL_W-1:0] rest;
        logic                  carry;
        logic                  renorm;
        qmbae_pkg::result_t    beat;

        idx = (state_ptr >= TABLE_DEPTH) ? TABLE_DEPTH - 1 : state_ptr;
        est = est_table[idx];
        rest = span - {1'b0, est};
        carry = 1'b0;
        renorm = 1'b1;

        if (symbol == mps)
        begin
            if (rest >= HALF_MARK)
            begin
                // no renormalization, nothing emitted
                span = rest;
                renorm = 1'b0;
            end
            else
            begin
                // conditional exchange
                if (rest < {1'b0, est})
                begin
                    add_to_code(rest, carry);
                    rest = {1'b0, est};
                end
                next_ptr = idx + up_table[idx];
                state_ptr = (next_ptr > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : next_ptr;
            end
        end
        else
        begin
            if (rest >= {1'b0, est})
            begin
                add_to_code(rest, carry);
                rest = {1'b0, est};
            end
            if (down_table[idx] == qmbae_pkg::STEP_DOWN_SWAP)
                mps = ~mps;
            state_ptr = (idx >= down_table[idx]) ? idx - down_table[idx] : 0;
        end

        if (renorm)
        begin
            emitted = 0;
            shifts = 0;
            if (carry)
            begin
                beat.out_bit = 1'b1;
                beat.last_of_run = 1'b0;
                code_bits_q.push_back(beat);
                emitted++;
            end
            while (rest < HALF_MARK && shifts < qmbae_pkg::MAX_SHIFTS)
            begin
                rest = rest << 1;
                beat.out_bit = low_code[CODE_W-1];
                beat.last_of_run = 1'b0;
                code_bits_q.push_back(beat);
                low_code = low_code << 1;
                emitted++;
                shifts++;
            end
            span = rest;
            // mark the final bit of this item
            if (emitted > 0)
            begin
                beat = code_bits_q.pop_back();
                beat.last_of_run = 1'b1;
                code_bits_q.push_back(beat);
            end
        end
    endtask

    // compare result beats, then predict from accepted item beats
    always @(posedge clk or negedge rst_n)
    begin
        qmbae_pkg::result_t want;
        if (!rst_n)
        begin
            state_ptr = 0;
            span = qmbae_pkg::INTERVAL_RESET;
            low_code = qmbae_pkg::CODE_RESET;
            mps = 1'b0;
            code_bits_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (code_bits_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected code bit beat out_bit=%0b last=%0b",
                                 $realtime, result.out_bit, result.last_of_run);
                    fail_count++;
                end
                else
                begin
                    want = code_bits_q.pop_front();
                    if (result.out_bit !== want.out_bit
                        || result.last_of_run !== want.last_of_run)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display({"%0t: code bit mismatch out_bit exp %0b got %b,",
                                      " last exp %0b got %b"},
                                     $realtime, want.out_bit, result.out_bit,
                                     want.last_of_run, result.last_of_run);
                        fail_count++;
                    end
                end
            end

            if (item_valid && !item_stall)
            begin
                if (item.action == qmbae_pkg::ACT_LOAD)
                begin
                    if (item.entry_index < TABLE_DEPTH)
                    begin
                        est_table[item.entry_index] = item.entry_prob;
                        up_table[item.entry_index] = item.entry_step_up;
                        down_table[item.entry_index] = item.entry_step_down;
                    end
                end
                else
                begin
                    encode_symbol(item.bit_value);
                end
            end

            pending = code_bits_q.size();
        end
    end

endmodule

[sim/qm_binary_arithmetic_encoder_core_test.sv]
// qm_binary_arithmetic_encoder_core_test: stimulus and verdict for the qm encoder
// loads probability tables, codes directed and random bit streams with random gaps
// depends on qmbae_pkg, qm_binary_arithmetic_encoder_core and qmbae_code_bit_checker

module qm_binary_arithmetic_encoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = qmbae_pkg::DEFAULT_TABLE_DEPTH;
    localparam int RANDOM_ITEMS = 400;
    localparam int IDLE_MAX     = 12;
    localparam int DRAIN_CYCLES = 40;
    // watchdog limit, sized for the slowest run with the largest gaps and stalls
    localparam int CYCLE_LIMIT  = 1_500_000;

    typedef enum int {PROFILE_LADDER, PROFILE_CLIMB, PROFILE_WILD} profile_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    qmbae_pkg::item_t   item;
    logic               result_valid;
    logic               result_stall;
    qmbae_pkg::result_t result;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int gap_max = 0;
    int stall_max = 0;

    qm_binary_arithmetic_encoder_core #(
        .TABLE_DEPTH (DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    qmbae_code_bit_checker #(
        .TABLE_DEPTH (DEPTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // result side: random stall before each code bit beat
    initial
    begin
        int hold;
        result_stall = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            result_stall = (hold > 0);
            @(posedge clk);
            if (result_valid && !result_stall)
                hold = $urandom_range(0, stall_max);
            else if (result_valid && hold > 0)
                hold--;
        end
    end

    function automatic qmbae_pkg::item_t make_entry(input int idx, input int prob,
                                                    input int up, input int down);
        qmbae_pkg::item_t beat;
        beat.action = qmbae_pkg::ACT_LOAD;
        beat.bit_value = 1'($urandom_range(0, 1));
        beat.entry_index = 6'(idx);
        beat.entry_prob = 16'(prob);
        beat.entry_step_up = 1'(up);
        beat.entry_step_down = 2'(down);
        return beat;
    endfunction

    // table entry content shaped by profile
    function automatic qmbae_pkg::item_t make_load(input int idx, input profile_t prof);
        int prob;
        int up;
        int down;
        case (prof)
            PROFILE_LADDER:
            begin
                prob = $urandom_range(16'h0400, 16'h5A1D) >> (idx / 16);
                up = ($urandom_range(0, 7) != 0);
                down = $urandom_range(0, 3);
            end
            PROFILE_CLIMB:
            begin
                prob = $urandom_range(16'h3000, 16'h5A1D);
                up = 1;
                down = ($urandom_range(0, 5) == 0) ? qmbae_pkg::STEP_DOWN_SWAP
                                                   : $urandom_range(1, 3);
            end
            default:
            begin
                case ($urandom_range(0, 7))
                    0:       prob = 16'h0000;
                    1:       prob = 16'hFFFF;
                    default: prob = $urandom_range(0, 16'hFFFF);
                endcase
                up = $urandom_range(0, 1);
                down = $urandom_range(0, 3);
            end
        endcase
        return make_entry(idx, prob, up, down);
    endfunction

    // encode beat, unused fields carry noise
    function automatic qmbae_pkg::item_t make_encode(input logic symbol);
        qmbae_pkg::item_t beat;
        beat.action = qmbae_pkg::ACT_ENCODE;
        beat.bit_value = symbol;
        beat.entry_index = 6'($urandom_range(0, 63));
        beat.entry_prob = 16'($urandom_range(0, 16'hFFFF));
        beat.entry_step_up = 1'($urandom_range(0, 1));
        beat.entry_step_down = 2'($urandom_range(0, 3));
        return beat;
    endfunction

    // drive one item beat after a random gap, return once it is taken
    task automatic send_item(input qmbae_pkg::item_t beat);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = beat;
        item_valid = 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off until every code bit has come out
    task automatic wait_drained();
        item_valid = 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
    endtask

    // stimulus and verdict
    initial
    begin
        profile_t prof;
        int       rand_items;
        int       phase_len;
        int       bias;
        int       k;

        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        rand_items = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero estimate: lps right after reset carries, then a zero interval
        gap_max = 2;
        stall_max = 2;
        send_item(make_entry(0, 16'h0000, 0, qmbae_pkg::STEP_DOWN_SWAP));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b1));
        // estimate above interval wraps, step-down three saturates at zero
        send_item(make_entry(0, 16'hFFFF, 0, 3));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b0));
        // regular entries, pointer moves between the first two entries
        send_item(make_entry(63, 16'h5A1D, 1, 2));
        send_item(make_entry(1, 16'h2586, 0, 3));
        send_item(make_entry(0, 16'h5A1D, 1, 1));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b0));
        // swap from the second entry
        send_item(make_entry(1, 16'h1000, 0, qmbae_pkg::STEP_DOWN_SWAP));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b0));
        send_item(make_encode(1'b1));
        send_item(make_encode(1'b1));

        // random phases, each with a freshly programmed table
        while (rand_items < RANDOM_ITEMS)
        begin
            wait_drained();
            prof = profile_t'($urandom_range(0, 2));
            case ($urandom_range(0, 3))
                0:
                begin
                    gap_max = 0;
                    stall_max = 0;
                end
                1:
                begin
                    gap_max = IDLE_MAX;
                    stall_max = 0;
                end
                2:
                begin
                    gap_max = 0;
                    stall_max = IDLE_MAX;
                end
                default:
                begin
                    gap_max = IDLE_MAX;
                    stall_max = IDLE_MAX;
                end
            endcase
            for (k = 0; k < DEPTH; k++)
            begin
                send_item(make_load(k, prof));
                rand_items++;
            end

            // long runs of one symbol drive the pointer toward the table ends
            case ($urandom_range(0, 2))
                0:       bias = $urandom_range(0, 10);
                1:       bias = $urandom_range(90, 100);
                default: bias = $urandom_range(20, 80);
            endcase
            phase_len = $urandom_range(50, 90);
            for (k = 0; k < phase_len && rand_items < RANDOM_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 8)
                    send_item(make_load($urandom_range(0, DEPTH - 1), prof));
                else
                    send_item(make_encode($urandom_range(0, 99) < bias));
                rand_items++;
            end
        end

        item_valid = 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
